>>> design/lfc_pkg.sv
package lfc_pkg;

	// Frame layout: byte offsets of the header fields
	localparam int unsigned CNT_W = 32;
	localparam logic [CNT_W-1:0] OFS_CRC    = 32'd4;
	localparam logic [CNT_W-1:0] OFS_SEQ    = 32'd8;
	localparam logic [CNT_W-1:0] OFS_KIND   = 32'd16;
	localparam logic [CNT_W-1:0] OFS_TIME   = 32'd17;
	localparam logic [CNT_W-1:0] OFS_ACTOR  = 32'd25;
	localparam logic [CNT_W-1:0] OFS_CONV   = 32'd27;
	localparam logic [CNT_W-1:0] HEADER_BYTES = 32'd43;
	localparam logic [CNT_W-1:0] CNT_MAX    = '1;

	// Configuration register reset values
	localparam logic [31:0] MAX_FRAME_RST = 32'd1048576;
	localparam logic [7:0]  KIND_MIN_RST  = 8'd1;
	localparam logic [7:0]  KIND_MAX_RST  = 8'd255;

	localparam logic [31:0] CRC32C_POLY = 32'h82F63B78;

	// Result queue
	localparam int unsigned OUT_DEPTH = 4;
	localparam int unsigned OUT_PTR_W = $clog2(OUT_DEPTH);

	localparam int unsigned TDATA_W = 168;

	typedef enum logic [1:0] {
		REG_MAX_FRAME = 2'd0,
		REG_KIND_MIN  = 2'd1,
		REG_KIND_MAX  = 2'd2
	} reg_idx_t;

	typedef enum logic [1:0] {
		ITEM_CONV    = 2'd0,
		ITEM_PAYLOAD = 2'd1,
		ITEM_VERDICT = 2'd2
	} item_type_t;

	typedef enum logic [2:0] {
		VERD_OK    = 3'd0,
		VERD_TRUNC = 3'd1,
		VERD_LEN   = 3'd2,
		VERD_KIND  = 3'd3,
		VERD_CRC   = 3'd4
	} verdict_t;

	typedef struct packed {
		logic [31:0] max_frame_bytes;
		logic [7:0]  kind_min;
		logic [7:0]  kind_max;
	} cfg_t;

	typedef struct packed {
		item_type_t         item_type;
		logic [7:0]         data_byte;
		logic [63:0]        sequence_number;
		logic [7:0]         event_kind;
		logic signed [63:0] wall_time_ns;
		logic [15:0]        actor_id;
		verdict_t           verdict;
		logic               frame_done;
	} result_t;

	// Reflected CRC-32C update by one byte
	function automatic logic [31:0] crc32c_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC32C_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

>>> design/lfc_parse.sv
module lfc_parse (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  fire,
	input  logic [7:0]            in_byte,
	input  logic                  end_of_buffer,
	input  lfc_pkg::cfg_t         cfg,
	output logic [1:0]            push_n,
	output lfc_pkg::result_t [1:0] push_data
);
	import lfc_pkg::*;

	logic [CNT_W-1:0] cnt_q, cnt_n;
	logic [31:0]      len_q, len_n;
	logic             len_bad_q, len_bad_n;
	logic [31:0]      crc_st_q, crc_st_n;
	logic [31:0]      crc_q, crc_n;
	logic [63:0]      seq_q, seq_n;
	logic [7:0]       kind_q, kind_n;
	logic [63:0]      time_q, time_n;
	logic [15:0]      actor_q, actor_n;
	logic             fwd;
	logic [2:0]       tsel;
	logic             asel;
	verdict_t         verd;
	result_t          fwd_res, verd_res;

	assign tsel = cnt_q[2:0] - OFS_TIME[2:0];
	assign asel = cnt_q[0] ^ OFS_ACTOR[0];

	// Capture header bytes by position
	always_comb begin
		len_n     = len_q;
		len_bad_n = len_bad_q;
		crc_st_n  = crc_st_q;
		seq_n     = seq_q;
		kind_n    = kind_q;
		time_n    = time_q;
		actor_n   = actor_q;
		fwd       = 1'b0;
		priority if (cnt_q < OFS_CRC) begin
			len_n[{cnt_q[1:0], 3'b000} +: 8] = in_byte;
			if (cnt_q == OFS_CRC - 32'd1) begin
				len_bad_n = (len_n < HEADER_BYTES) || (len_n > cfg.max_frame_bytes);
			end
		end else if (cnt_q < OFS_SEQ) begin
			crc_st_n[{cnt_q[1:0], 3'b000} +: 8] = in_byte;
		end else if (cnt_q < OFS_KIND) begin
			seq_n[{cnt_q[2:0], 3'b000} +: 8] = in_byte;
		end else if (cnt_q == OFS_KIND) begin
			kind_n = in_byte;
		end else if (cnt_q < OFS_ACTOR) begin
			time_n[{tsel, 3'b000} +: 8] = in_byte;
		end else if (cnt_q < OFS_CONV) begin
			actor_n[{asel, 3'b000} +: 8] = in_byte;
		end else begin
			fwd = 1'b1;
		end
	end

	// Checksum covers byte 8 onward; counter saturates
	assign crc_n = (cnt_q >= OFS_SEQ) ? crc32c_byte(crc_q, in_byte) : crc_q;
	assign cnt_n = (cnt_q == CNT_MAX) ? cnt_q : cnt_q + 32'd1;

	// Judge the frame in priority order
	always_comb begin
		priority if (cnt_n < OFS_CRC) begin
			verd = VERD_TRUNC;
		end else if (len_bad_n) begin
			verd = VERD_LEN;
		end else if (cnt_n != len_n) begin
			verd = VERD_TRUNC;
		end else if (seq_n == 64'd0 || kind_n < cfg.kind_min || kind_n > cfg.kind_max) begin
			verd = VERD_KIND;
		end else if (~crc_n != crc_st_n) begin
			verd = VERD_CRC;
		end else begin
			verd = VERD_OK;
		end
	end

	// Build result beats
	always_comb begin
		fwd_res           = '0;
		fwd_res.item_type = (cnt_q < HEADER_BYTES) ? ITEM_CONV : ITEM_PAYLOAD;
		fwd_res.data_byte = in_byte;

		verd_res                 = '0;
		verd_res.item_type       = ITEM_VERDICT;
		verd_res.sequence_number = seq_n;
		verd_res.event_kind      = kind_n;
		verd_res.wall_time_ns    = time_n;
		verd_res.actor_id        = actor_n;
		verd_res.verdict         = verd;
		verd_res.frame_done      = 1'b1;

		push_data[0] = fwd ? fwd_res : verd_res;
		push_data[1] = verd_res;
		push_n       = fire ? ({1'b0, fwd} + {1'b0, end_of_buffer}) : 2'd0;
	end

	// Advance frame state; clear after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			len_q     <= '0;
			len_bad_q <= 1'b0;
			crc_st_q  <= '0;
			crc_q     <= '1;
			seq_q     <= '0;
			kind_q    <= '0;
			time_q    <= '0;
			actor_q   <= '0;
		end else if (fire) begin
			if (end_of_buffer) begin
				cnt_q     <= '0;
				len_q     <= '0;
				len_bad_q <= 1'b0;
				crc_st_q  <= '0;
				crc_q     <= '1;
				seq_q     <= '0;
				kind_q    <= '0;
				time_q    <= '0;
				actor_q   <= '0;
			end else begin
				cnt_q     <= cnt_n;
				len_q     <= len_n;
				len_bad_q <= len_bad_n;
				crc_st_q  <= crc_st_n;
				crc_q     <= crc_n;
				seq_q     <= seq_n;
				kind_q    <= kind_n;
				time_q    <= time_n;
				actor_q   <= actor_n;
			end
		end
	end

endmodule

>>> design/lfc_out_fifo.sv
module lfc_out_fifo (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [1:0]             push_n,
	input  lfc_pkg::result_t [1:0] push_data,
	output logic                   space_ok,
	output logic                   head_valid,
	input  logic                   head_pop,
	output lfc_pkg::result_t       head
);
	import lfc_pkg::*;

	result_t              mem_q [OUT_DEPTH];
	logic [OUT_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [OUT_PTR_W:0]   count_q;
	logic                 pop;

	// Room for the two beats one byte can cause
	assign space_ok   = count_q <= (OUT_PTR_W+1)'(OUT_DEPTH - 2);
	assign head_valid = count_q != '0;
	assign pop        = head_valid && head_pop;
	assign head       = mem_q[rd_ptr_q];

	// Store up to two beats per cycle
	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			mem_q[wr_ptr_q] <= push_data[0];
		end
		if (push_n == 2'd2) begin
			mem_q[wr_ptr_q + OUT_PTR_W'(1)] <= push_data[1];
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + OUT_PTR_W'(push_n);
			rd_ptr_q <= rd_ptr_q + OUT_PTR_W'(pop);
			count_q  <= count_q + (OUT_PTR_W+1)'(push_n) - (OUT_PTR_W+1)'(pop);
		end
	end

endmodule

>>> design/log_frame_checker_crc32c_core.sv
// Channel   Dir  tdata                                     tuser      tlast
// s_axis    in   [7:0] in_byte                             -          end_of_buffer
// m_axis    out  [7:0] data_byte, [71:8] sequence_number,  [1:0]      frame_done
//                [79:72] event_kind, [143:80] wall_time_ns, item_type
//                [159:144] actor_id, [162:160] verdict
// cfg       in   cfg_wr_en / cfg_index / cfg_data (write only)
//
// One input byte per cycle while s_axis_tready is high; header capture and the
// bytewise CRC-32C update finish in the accept cycle that queues the beats.
// A last byte that lands past the header fields queues two beats (forwarded
// byte, then verdict); a last byte inside them queues only the verdict.
// s_axis_tready drops only while the four-entry result queue has fewer than
// two free slots, i.e. when m_axis is stalled.
// arst_n clears the frame state and queue and restores register defaults.
module log_frame_checker_crc32c_core (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [7:0]   s_axis_tdata,  // in_byte
	input  logic         s_axis_tlast,  // end_of_buffer
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [lfc_pkg::TDATA_W-1:0] m_axis_tdata,  // data_byte, sequence_number,
	                                    // event_kind, wall_time_ns, actor_id, verdict,
	                                    // zero fill
	output logic [1:0]   m_axis_tuser,  // item_type
	output logic         m_axis_tlast,  // frame_done
	input  logic         cfg_wr_en,
	input  logic [1:0]   cfg_index,
	input  logic [31:0]  cfg_data
);
	import lfc_pkg::*;

	cfg_t            cfg_q;
	logic            s_fire;
	logic [1:0]      push_n;
	result_t [1:0]   push_data;
	result_t         head;

	assign s_fire = s_axis_tvalid && s_axis_tready;

	// Hold configuration registers; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_frame_bytes <= MAX_FRAME_RST;
			cfg_q.kind_min        <= KIND_MIN_RST;
			cfg_q.kind_max        <= KIND_MAX_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_MAX_FRAME: cfg_q.max_frame_bytes <= cfg_data;
				REG_KIND_MIN:  cfg_q.kind_min        <= cfg_data[7:0];
				REG_KIND_MAX:  cfg_q.kind_max        <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	lfc_parse u_parse (
		.clk           (clk),
		.arst_n        (arst_n),
		.fire          (s_fire),
		.in_byte       (s_axis_tdata),
		.end_of_buffer (s_axis_tlast),
		.cfg           (cfg_q),
		.push_n        (push_n),
		.push_data     (push_data)
	);

	lfc_out_fifo u_out_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_n     (push_n),
		.push_data  (push_data),
		.space_ok   (s_axis_tready),
		.head_valid (m_axis_tvalid),
		.head_pop   (m_axis_tready),
		.head       (head)
	);

	// Pack the head beat onto the master side
	assign m_axis_tdata = {5'd0, head.verdict, head.actor_id, head.wall_time_ns,
	                       head.event_kind, head.sequence_number, head.data_byte};
	assign m_axis_tuser = head.item_type;
	assign m_axis_tlast = head.frame_done;

`ifndef NO_ASSERTIONS
	// An empty queue always takes input
	a_idle_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled while result queue empty");

	// A frame's last byte leaves a verdict pending
	a_last_gives_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(s_fire && s_axis_tlast) |=> m_axis_tvalid)
		else $error("no result after last byte");

	// Forwarded beats carry no verdict
	a_fwd_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tlast) |->
		(m_axis_tdata[162:160] == VERD_OK && m_axis_tuser != ITEM_VERDICT))
		else $error("forwarded beat marked as verdict");

	// A verdict beat is typed as such
	a_verdict_type: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tlast) |-> (m_axis_tuser == ITEM_VERDICT))
		else $error("frame end beat not a verdict");
`endif

endmodule

>>> tb/tb_log_frame_checker_crc32c_core.sv
module tb_log_frame_checker_crc32c_core;
	timeunit 1ns;
	timeprecision 1ps;

	import lfc_pkg::*;

	// Index with no register behind it
	localparam logic [1:0] REG_UNUSED = 2'd3;
	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned HOLD_CYCLES = 300;
	localparam int unsigned TAIL_CYCLES = 8;
	localparam int unsigned RAND_FRAMES = 6;
	localparam int unsigned PHASE_FRAMES = 2;

	// Tracks one frame in flight and the beats it must produce
	class log_frame_tracker;
		result_t     due_beats[$];
		int unsigned mismatches;

		logic [31:0] max_frame;
		logic [7:0]  kind_lo;
		logic [7:0]  kind_hi;

		logic [31:0] byte_count;
		logic [31:0] length_word;
		bit          length_bad;
		logic [31:0] stored_crc;
		logic [31:0] running_crc;
		logic [63:0] seq_acc;
		logic [7:0]  kind_acc;
		logic [63:0] time_acc;
		logic [15:0] actor_acc;

		// Reflected CRC-32C, one message bit at a time
		static function logic [31:0] crc32c_step(logic [31:0] crc, logic [7:0] b);
			logic [31:0] c;
			c = crc;
			for (int k = 0; k < 8; k++) begin
				c = (c >> 1) ^ (CRC32C_POLY & {32{c[0] ^ b[k]}});
			end
			return c;
		endfunction

		function void clear_frame();
			byte_count  = '0;
			length_word = '0;
			length_bad  = 1'b0;
			stored_crc  = '0;
			running_crc = '1;
			seq_acc     = '0;
			kind_acc    = '0;
			time_acc    = '0;
			actor_acc   = '0;
		endfunction

		function void restore_defaults();
			max_frame = MAX_FRAME_RST;
			kind_lo   = KIND_MIN_RST;
			kind_hi   = KIND_MAX_RST;
			mismatches = 0;
			clear_frame();
		endfunction

		function void write_reg(logic [1:0] idx, logic [31:0] val);
			case (idx)
				REG_MAX_FRAME: max_frame = val;
				REG_KIND_MIN:  kind_lo = val[7:0];
				REG_KIND_MAX:  kind_hi = val[7:0];
				default: ;
			endcase
		endfunction

		// Capture one accepted byte; queue the forwarded byte and, on the last
		// byte, the verdict
		function void take_byte(logic [7:0] b, bit last);
			result_t     r;
			verdict_t    v;
			logic [31:0] idx;
			idx = byte_count;
			if (idx < OFS_CRC) begin
				length_word[8*idx[1:0] +: 8] = b;
				if (idx == 32'd3)
					length_bad = (length_word < HEADER_BYTES) || (length_word > max_frame);
			end else if (idx < OFS_SEQ) begin
				stored_crc[8*idx[1:0] +: 8] = b;
			end else if (idx < OFS_KIND) begin
				seq_acc[8*idx[2:0] +: 8] = b;
			end else if (idx == OFS_KIND) begin
				kind_acc = b;
			end else if (idx < OFS_ACTOR) begin
				time_acc[8*(idx - OFS_TIME) +: 8] = b;
			end else if (idx < OFS_CONV) begin
				actor_acc[8*(idx - OFS_ACTOR) +: 8] = b;
			end else begin
				r = '0;
				r.item_type = (idx < HEADER_BYTES) ? ITEM_CONV : ITEM_PAYLOAD;
				r.data_byte = b;
				due_beats.push_back(r);
			end

			if (idx >= OFS_SEQ)
				running_crc = crc32c_step(running_crc, b);
			if (byte_count != CNT_MAX)
				byte_count++;

			if (last) begin
				if (byte_count < 32'd4)
					v = VERD_TRUNC;
				else if (length_bad)
					v = VERD_LEN;
				else if (byte_count != length_word)
					v = VERD_TRUNC;
				else if (seq_acc == '0 || kind_acc < kind_lo || kind_acc > kind_hi)
					v = VERD_KIND;
				else if (~running_crc != stored_crc)
					v = VERD_CRC;
				else
					v = VERD_OK;
				r = '0;
				r.item_type       = ITEM_VERDICT;
				r.sequence_number = seq_acc;
				r.event_kind      = kind_acc;
				r.wall_time_ns    = time_acc;
				r.actor_id        = actor_acc;
				r.verdict         = v;
				r.frame_done      = 1'b1;
				due_beats.push_back(r);
				clear_frame();
			end
		endfunction

		function void compare_field(string name, logic [63:0] want, logic [63:0] got);
			if (want !== got) begin
				mismatches++;
				$display("%0t %s mismatch: expected %h actual %h", $time, name, want, got);
			end
		endfunction

		// Check an output beat against the oldest pending one
		function void match_beat(result_t got);
			result_t want;
			if (due_beats.size() == 0) begin
				mismatches++;
				$display("%0t unexpected beat: expected none actual %h", $time, got);
				return;
			end
			want = due_beats.pop_front();
			compare_field("item_type", want.item_type, got.item_type);
			compare_field("data_byte", want.data_byte, got.data_byte);
			compare_field("sequence_number", want.sequence_number, got.sequence_number);
			compare_field("event_kind", want.event_kind, got.event_kind);
			compare_field("wall_time_ns", want.wall_time_ns, got.wall_time_ns);
			compare_field("actor_id", want.actor_id, got.actor_id);
			compare_field("verdict", want.verdict, got.verdict);
			compare_field("frame_done", want.frame_done, got.frame_done);
		endfunction
	endclass

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [7:0]   s_axis_tdata;
	logic         s_axis_tlast;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [167:0] m_axis_tdata;
	logic [1:0]   m_axis_tuser;
	logic         m_axis_tlast;
	logic         cfg_wr_en;
	logic [1:0]   cfg_index;
	logic [31:0]  cfg_data;

	log_frame_tracker tracker;
	logic [7:0]       frame_buf[$];
	bit               no_gaps;
	bit               hold_go;
	int unsigned      frames_sent;
	int unsigned      cycles;

	log_frame_checker_crc32c_core u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Give up after a generous number of cycles
	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("TB_ERROR");
		$finish;
	end

	// Sink: random stalls, one long hold-off on request
	initial begin
		int unsigned hold_left;
		hold_left = 0;
		m_axis_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left != 0) begin
				m_axis_tready <= 1'b0;
				hold_left--;
			end else if (hold_go) begin
				hold_go = 1'b0;
				hold_left = HOLD_CYCLES - 1;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= no_gaps || ($urandom_range(99) >= 24);
			end
		end
	end

	// Sample output beats between edges, check them at the accepting edge
	initial begin
		result_t got;
		bit      fire;
		forever begin
			@(negedge clk);
			fire = (m_axis_tvalid === 1'b1) && (m_axis_tready === 1'b1);
			got.item_type       = item_type_t'(m_axis_tuser);
			got.data_byte       = m_axis_tdata[7:0];
			got.sequence_number = m_axis_tdata[71:8];
			got.event_kind      = m_axis_tdata[79:72];
			got.wall_time_ns    = m_axis_tdata[143:80];
			got.actor_id        = m_axis_tdata[159:144];
			got.verdict         = verdict_t'(m_axis_tdata[162:160]);
			got.frame_done      = m_axis_tlast;
			@(posedge clk);
			if (fire)
				tracker.match_beat(got);
		end
	end

	// Offer one byte, with random idle cycles ahead of it
	task automatic send_byte(input logic [7:0] b, input bit last);
		bit ready_seen;
		while (!no_gaps && $urandom_range(99) < 24) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tlast  <= last;
		ready_seen = 1'b0;
		while (!ready_seen) begin
			@(negedge clk);
			ready_seen = (s_axis_tready === 1'b1);
			@(posedge clk);
		end
		tracker.take_byte(b, last);
	endtask

	task automatic send_frame();
		for (int i = 0; i < frame_buf.size(); i++) begin
			send_byte(frame_buf[i], i == frame_buf.size() - 1);
		end
	endtask

	// Stop offering and let every pending beat drain
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (tracker.due_beats.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	task automatic write_cfg(input logic [1:0] idx, input logic [31:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		tracker.write_reg(idx, val);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	// Build n bytes of a frame with a correct CRC over byte 8 onward
	function automatic void make_frame(int unsigned n, logic [31:0] len_field,
			logic [63:0] seq, logic [7:0] kind, logic [63:0] stamp, logic [15:0] actor);
		logic [31:0] crc;
		int unsigned fill;
		frame_buf.delete();
		fill = (n < OFS_CONV) ? OFS_CONV : n;
		repeat (fill) frame_buf.push_back(8'($urandom));
		for (int i = 0; i < 4; i++) begin
			frame_buf[i] = len_field[8*i +: 8];
		end
		for (int i = 0; i < 8; i++) begin
			frame_buf[OFS_SEQ + i]  = seq[8*i +: 8];
			frame_buf[OFS_TIME + i] = stamp[8*i +: 8];
		end
		frame_buf[OFS_KIND]      = kind;
		frame_buf[OFS_ACTOR]     = actor[7:0];
		frame_buf[OFS_ACTOR + 1] = actor[15:8];
		crc = '1;
		for (int i = OFS_SEQ; i < n; i++) begin
			crc = log_frame_tracker::crc32c_step(crc, frame_buf[i]);
		end
		crc = ~crc;
		for (int i = 0; i < 4; i++) begin
			frame_buf[OFS_CRC + i] = crc[8*i +: 8];
		end
		while (frame_buf.size() > n)
			void'(frame_buf.pop_back());
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// Kind inside the configured range when the range is not empty
	function automatic logic [7:0] pick_kind();
		if (tracker.kind_lo <= tracker.kind_hi)
			return 8'($urandom_range(tracker.kind_hi, tracker.kind_lo));
		return 8'($urandom);
	endfunction

	// Mostly well-formed frames; the rest broken in one way or another
	task automatic random_frame();
		int unsigned r;
		int unsigned n;
		int unsigned pos;
		logic [31:0] len;
		logic [63:0] seq;
		logic [7:0]  kind;
		r = $urandom_range(99);
		n = 43 + (($urandom_range(9) == 0) ? $urandom_range(60) : $urandom_range(17));
		len = n;
		seq = rand64();
		if (seq == '0)
			seq = 64'd1;
		kind = pick_kind();
		if (r >= 63 && r < 68)
			seq = '0;
		else if (r >= 68 && r < 73)
			kind = 8'($urandom);
		else if (r >= 73 && r < 80)
			n = 1 + $urandom_range(44);
		else if (r >= 80 && r < 86)
			len = $urandom;
		else if (r >= 86 && r < 92)
			n = len + 1 + $urandom_range(4);
		else if (r >= 92)
			n = 1 + $urandom_range(11);
		make_frame(n, len, seq, kind, rand64(), 16'($urandom));
		if (r >= 55 && r < 63) begin
			// flip one bit past the length word
			pos = 4 + $urandom_range(n - 5);
			frame_buf[pos] ^= 8'd1 << $urandom_range(7);
		end else if (r >= 92) begin
			foreach (frame_buf[i]) frame_buf[i] = 8'($urandom);
		end
		send_frame();
		frames_sent++;
	endtask

	task automatic random_config();
		logic [31:0] m;
		logic [7:0]  lo;
		logic [7:0]  hi;
		case ($urandom_range(7))
			0: m = 32'd0;
			1: m = HEADER_BYTES - 1;
			2: m = HEADER_BYTES;
			3: m = 32'hFFFF_FFFF;
			4: m = 43 + $urandom_range(40);
			default: m = MAX_FRAME_RST;
		endcase
		case ($urandom_range(3))
			0: lo = 8'd0;
			1: lo = 8'($urandom);
			default: lo = KIND_MIN_RST;
		endcase
		case ($urandom_range(3))
			0: hi = 8'($urandom);
			1: hi = 8'd0;
			default: hi = KIND_MAX_RST;
		endcase
		write_cfg(REG_MAX_FRAME, m);
		write_cfg(REG_KIND_MIN, {24'd0, lo});
		write_cfg(REG_KIND_MAX, {24'd0, hi});
		if ($urandom_range(3) == 0)
			write_cfg(REG_UNUSED, $urandom);
	endtask

	initial begin
		int unsigned ph;
		tracker = new;
		tracker.restore_defaults();
		no_gaps       = 1'b0;
		hold_go       = 1'b0;
		frames_sent   = 0;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tlast  = 1'b0;
		cfg_wr_en     = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Frames shorter than the length word, and one that stops right after it
		make_frame(1, 32'd0, '0, '0, '0, '0);
		frame_buf[0] = 8'hFF;
		send_frame();
		make_frame(3, 32'd0, '0, '0, '0, '0);
		send_frame();
		make_frame(4, HEADER_BYTES, '0, '0, '0, '0);
		send_frame();

		// Minimal good frame with extreme header fields, then one with payload
		make_frame(43, 43, '1, 8'd255, 64'h8000_0000_0000_0000, 16'hFFFF);
		send_frame();
		make_frame(46, 46, 64'd1, 8'd1, 64'h7FFF_FFFF_FFFF_FFFF, 16'h0000);
		send_frame();

		// Length below the header, length above the limit
		make_frame(42, 42, rand64(), 8'd5, rand64(), 16'($urandom));
		send_frame();
		make_frame(44, 32'hFFFF_FFFF, rand64(), 8'd5, rand64(), 16'($urandom));
		send_frame();

		// Kind below the range, zero sequence number, bad checksum
		make_frame(45, 45, rand64() | 64'd1, 8'd0, rand64(), 16'($urandom));
		send_frame();
		make_frame(45, 45, 64'd0, 8'd9, rand64(), 16'($urandom));
		send_frame();
		make_frame(45, 45, rand64() | 64'd1, 8'd9, rand64(), 16'($urandom));
		frame_buf[44] ^= 8'h80;
		send_frame();

		// Bytes past the length still go out as payload
		make_frame(47, 43, rand64() | 64'd1, 8'd9, rand64(), 16'($urandom));
		send_frame();
		wait_drained();

		// Empty kind range, limit at the header size, ignored index
		write_cfg(REG_MAX_FRAME, HEADER_BYTES);
		write_cfg(REG_KIND_MIN, 32'd10);
		write_cfg(REG_KIND_MAX, 32'd5);
		write_cfg(REG_UNUSED, 32'hFFFF_FFFF);
		make_frame(43, 43, rand64() | 64'd1, 8'd7, rand64(), 16'($urandom));
		send_frame();
		make_frame(44, 44, rand64() | 64'd1, 8'd7, rand64(), 16'($urandom));
		send_frame();
		wait_drained();

		// Widest settings
		write_cfg(REG_MAX_FRAME, 32'hFFFF_FFFF);
		write_cfg(REG_KIND_MIN, 32'd0);
		write_cfg(REG_KIND_MAX, 32'd255);
		make_frame(50, 32'hFFFF_FFFF, rand64() | 64'd1, 8'd3, rand64(), 16'($urandom));
		send_frame();
		make_frame(43, 43, rand64() | 64'd1, 8'd0, rand64(), 16'($urandom));
		send_frame();
		wait_drained();

		// Limit changes after the length word: the old limit still applies
		make_frame(50, 50, rand64() | 64'd1, 8'd3, rand64(), 16'($urandom));
		for (int i = 0; i < 4; i++) begin
			send_byte(frame_buf[i], 1'b0);
		end
		wait_drained();
		write_cfg(REG_MAX_FRAME, 32'd0);
		for (int i = 4; i < 50; i++) begin
			send_byte(frame_buf[i], i == 49);
		end
		make_frame(43, 43, rand64() | 64'd1, 8'd3, rand64(), 16'($urandom));
		send_frame();
		wait_drained();

		// Random phases, each under its own settings; the first runs against
		// a long sink hold-off, the third without idle cycles
		ph = 0;
		while (frames_sent < RAND_FRAMES) begin
			random_config();
			no_gaps = (ph == 2);
			if (ph == 0)
				hold_go = 1'b1;
			repeat (PHASE_FRAMES) random_frame();
			wait_drained();
			ph++;
		end
		no_gaps = 1'b0;

		if (tracker.mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

>>> sim.f
design/lfc_pkg.sv
design/lfc_parse.sv
design/lfc_out_fifo.sv
design/log_frame_checker_crc32c_core.sv
tb/tb_log_frame_checker_crc32c_core.sv
